// ----- design/duplicate_frame_filter_mad_unit_defines.svh -----
// Assertion macros for the duplicate frame filter.
// Used by duplicate_frame_filter_mad_unit.sv; no other dependencies.
`ifndef DUPLICATE_FRAME_FILTER_MAD_UNIT_DEFINES_SVH
`define DUPLICATE_FRAME_FILTER_MAD_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DFFM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dffm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DFFM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dffm: next-cycle check failed");

`endif

// ----- design/dffm_pkg.sv -----
// Package for the duplicate frame filter: sizes, field widths, pipeline stage types.
// No dependencies.
package dffm_pkg;

  localparam int unsigned MAX_PIXELS = 65536;

  localparam int IDX_W      = $clog2(MAX_PIXELS);
  localparam int CNT_W      = $clog2(MAX_PIXELS + 2);
  localparam int MEM_DEPTH  = 2 ** (IDX_W + 1);
  localparam int CH_W       = 8;
  localparam int RGB_W      = 3 * CH_W;
  localparam int DIM_W      = 13;
  localparam int AREA_W     = 2 * DIM_W;
  localparam int TOL_W      = 16;
  localparam int DIFF_W     = CH_W + 2;
  localparam int SUM_W      = 26;
  localparam int ACC_NEED_W = $clog2(longint'(MAX_PIXELS) * 765 + 1);
  localparam int ACC_W      = (ACC_NEED_W > SUM_W) ? ACC_NEED_W : SUM_W;
  localparam int PROD_W     = TOL_W + AREA_W;
  localparam int PROD3_W    = PROD_W + 2;
  localparam int CMP_W      = (ACC_W + 8 > PROD3_W) ? ACC_W + 8 : PROD3_W;

  localparam longint SUM_MAX = 2 ** SUM_W - 1;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd256;

  localparam int IN_FIELD_W  = RGB_W + 2 * DIM_W;
  localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 2 + SUM_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Stage 1: pixel registered, reference pixel read from the store
  typedef struct packed {
    logic              last;
    logic              cmp_en;
    logic              dims_match;
    logic [CH_W-1:0]   blue;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   red;
    logic [CNT_W-1:0]  count;
    logic [AREA_W-1:0] area;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } s1_t;

  // Stage 2: per-pixel difference and tolerance product
  typedef struct packed {
    logic              last;
    logic              dims_match;
    logic              oversize;
    logic              mismatch;
    logic [DIFF_W-1:0] diff;
    logic [PROD_W-1:0] prod;
    logic [AREA_W-1:0] area;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } s2_t;

  // Stage 3: frame totals awaiting the verdict
  typedef struct packed {
    logic               dims_match;
    logic               oversize;
    logic               mismatch;
    logic [ACC_W-1:0]   sum;
    logic [PROD3_W-1:0] limit;
    logic [AREA_W-1:0]  area;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } s3_t;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

endpackage

// ----- design/duplicate_frame_filter_mad_unit.sv -----
// Duplicate frame filter by mean absolute difference, top level.
// Depends on dffm_pkg and duplicate_frame_filter_mad_unit_defines.svh.
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+----------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: blue, green, red, width, height
//           |     |                               | tlast: last pixel of the frame
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: keep_frame, oversize, diff sum
//  cfg      | in  | cfg_we_i (no wait)            | cfg_wdata_i: tolerance_q8
//
// Cycles: one pixel per clock inside a frame. After the last pixel of a frame the
// input stalls until the verdict is in the output register. That gap is the
// three-stage path read/diff -> accumulate -> compare, which has to finish before
// the next frame may look at the reference.
// Reset: async active low; no reference, bank 0, tolerance 1.0. The frame store
// has no reset and needs no clearing pass.
// Stalls: a held output only stops the verdict stage; the input reopens as soon as
// the verdict is loaded, even while the result waits to be taken.

`include "duplicate_frame_filter_mad_unit_defines.svh"

module duplicate_frame_filter_mad_unit
  import dffm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] blue, [15:8] green, [23:16] red, [36:24] width, [49:37] height, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] keep_frame, [1] oversize, [27:2] difference_sum, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [TOL_W-1:0]       cfg_wdata_i
);

  // ---------------------------------------------------------------- input fields
  logic [CH_W-1:0]   in_blue, in_green, in_red;
  logic [DIM_W-1:0]  in_width, in_height;
  logic [AREA_W-1:0] in_area;

  assign in_blue   = s_axis_tdata[CH_W-1:0];
  assign in_green  = s_axis_tdata[2*CH_W-1:CH_W];
  assign in_red    = s_axis_tdata[RGB_W-1:2*CH_W];
  assign in_width  = s_axis_tdata[RGB_W+DIM_W-1:RGB_W];
  assign in_height = s_axis_tdata[RGB_W+2*DIM_W-1:RGB_W+DIM_W];
  assign in_area   = AREA_W'(in_width) * AREA_W'(in_height);

  // ---------------------------------------------------------------- state
  logic [TOL_W-1:0]  tol_q;
  logic              ref_bank_q;
  logic              have_ref_q;
  logic [DIM_W-1:0]  ref_width_q, ref_height_q;
  logic [AREA_W-1:0] ref_area_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q;          // last pixel taken, verdict not yet loaded
  logic [ACC_W-1:0]  acc_q;

  logic              in_accept;
  logic              in_store;
  logic              dims_match;
  logic              cmp_en;
  logic [CNT_W-1:0]  cnt_inc;

  assign s_axis_tready = !busy_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign in_store   = cnt_q < CNT_W'(MAX_PIXELS);
  assign dims_match = have_ref_q && (in_width == ref_width_q) && (in_height == ref_height_q);
  // only pixels inside a fully delivered reference frame are compared
  assign cmp_en     = dims_match && in_store && (AREA_W'(cnt_q) < ref_area_q);
  assign cnt_inc    = (cnt_q < CNT_W'(MAX_PIXELS + 1)) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_d      = s_axis_tlast ? '0 : cnt_inc;

  // ---------------------------------------------------------------- frame store
  // Two banks; the free bank is written while the reference bank is read.
  logic [RGB_W-1:0] mem_q [MEM_DEPTH];
  logic [RGB_W-1:0] ref_pix_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      if (in_store) begin
        mem_q[{~ref_bank_q, cnt_q[IDX_W-1:0]}] <= {in_red, in_green, in_blue};
      end
      ref_pix_q <= mem_q[{ref_bank_q, cnt_q[IDX_W-1:0]}];
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic s1_valid_q;
  s1_t  s1_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.last       <= s_axis_tlast;
      s1_q.cmp_en     <= cmp_en;
      s1_q.dims_match <= dims_match;
      s1_q.blue       <= in_blue;
      s1_q.green      <= in_green;
      s1_q.red        <= in_red;
      s1_q.count      <= cnt_inc;
      s1_q.area       <= in_area;
      s1_q.width      <= in_width;
      s1_q.height     <= in_height;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic              s2_valid_q;
  s2_t               s2_q;
  logic [DIFF_W-1:0] pix_diff;

  assign pix_diff = s1_q.cmp_en
                  ? DIFF_W'(abs_diff(s1_q.blue,  ref_pix_q[CH_W-1:0]))
                  + DIFF_W'(abs_diff(s1_q.green, ref_pix_q[2*CH_W-1:CH_W]))
                  + DIFF_W'(abs_diff(s1_q.red,   ref_pix_q[RGB_W-1:2*CH_W]))
                  : '0;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_q.last       <= s1_q.last;
      s2_q.dims_match <= s1_q.dims_match;
      s2_q.oversize   <= s1_q.area > AREA_W'(MAX_PIXELS);
      s2_q.mismatch   <= AREA_W'(s1_q.count) != s1_q.area;
      s2_q.diff       <= pix_diff;
      s2_q.prod       <= PROD_W'(tol_q) * PROD_W'(s1_q.area);
      s2_q.area       <= s1_q.area;
      s2_q.width      <= s1_q.width;
      s2_q.height     <= s1_q.height;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Accumulate; on the last pixel capture the total and clear for the next frame.
  logic s3_valid_q;
  s3_t  s3_q;
  logic s2_last;

  assign s2_last = s2_valid_q && s2_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (s2_valid_q) begin
      acc_q <= s2_q.last ? '0 : acc_q + ACC_W'(s2_q.diff);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_last) begin
      s3_q.dims_match <= s2_q.dims_match;
      s3_q.oversize   <= s2_q.oversize;
      s3_q.mismatch   <= s2_q.mismatch;
      s3_q.sum        <= acc_q + ACC_W'(s2_q.diff);
      s3_q.limit      <= PROD3_W'(s2_q.prod) + {s2_q.prod, 1'b0};
      s3_q.area       <= s2_q.area;
      s3_q.width      <= s2_q.width;
      s3_q.height     <= s2_q.height;
    end
  end

  // ---------------------------------------------------------------- verdict
  logic             m_valid_q;
  logic             verdict_fire;
  logic             normal_frame;
  logic             is_dup;
  logic             keep_frame;
  logic [SUM_W-1:0] sum_out;

  assign verdict_fire = s3_valid_q && (!m_valid_q || m_axis_tready);
  assign normal_frame = !s3_q.oversize && !s3_q.mismatch;
  // sum*256 <= tolerance*pixels*3 stands in for the mean compare
  assign is_dup       = normal_frame && s3_q.dims_match
                     && (CMP_W'({s3_q.sum, 8'b0}) <= CMP_W'(s3_q.limit));
  assign keep_frame   = !is_dup;
  assign sum_out      = !(normal_frame && s3_q.dims_match) ? '0
                      : (s3_q.sum > ACC_W'(SUM_MAX)) ? SUM_W'(SUM_MAX)
                      : SUM_W'(s3_q.sum);

  always_ff @(posedge clk_i) begin
    if (verdict_fire) begin
      m_axis_tdata <= OUT_TDATA_W'({sum_out, s3_q.oversize, keep_frame});
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q        <= TOL_RESET;
      ref_bank_q   <= 1'b0;
      have_ref_q   <= 1'b0;
      ref_width_q  <= '0;
      ref_height_q <= '0;
      ref_area_q   <= '0;
      cnt_q        <= '0;
      busy_q       <= 1'b0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      s1_valid_q <= in_accept;
      s2_valid_q <= s1_valid_q;
      if (in_accept) begin
        cnt_q <= cnt_d;
        if (s_axis_tlast) begin
          busy_q <= 1'b1;
        end
      end
      if (s2_last) begin
        s3_valid_q <= 1'b1;
      end else if (verdict_fire) begin
        s3_valid_q <= 1'b0;
      end
      if (verdict_fire) begin
        busy_q    <= 1'b0;
        m_valid_q <= 1'b1;
        if (!normal_frame) begin
          have_ref_q <= 1'b0;
        end else if (!is_dup) begin
          ref_bank_q   <= ~ref_bank_q;
          have_ref_q   <= 1'b1;
          ref_width_q  <= s3_q.width;
          ref_height_q <= s3_q.height;
          ref_area_q   <= s3_q.area;
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;

  // ---------------------------------------------------------------- assertions
  // a kept reference always describes a frame that fits the store
  `DFFM_ASSERT_NOW(a_ref_area_ok, clk_i, rst_ni, have_ref_q, (ref_area_q != '0) && (ref_area_q <= AREA_W'(MAX_PIXELS)))
  // the input closes right after the last pixel of a frame
  `DFFM_ASSERT_NEXT(a_close_after_last, clk_i, rst_ni, in_accept && s_axis_tlast, !s_axis_tready)
  // a verdict in flight always belongs to a frame whose input is closed
  `DFFM_ASSERT_NOW(a_verdict_busy, clk_i, rst_ni, s3_valid_q, busy_q)
  // a loaded verdict is presented on the next cycle
  `DFFM_ASSERT_NEXT(a_verdict_shown, clk_i, rst_ni, verdict_fire, m_axis_tvalid)

endmodule
